// ===== hdl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg
// shared types and constants of the stream reassembly bitmap
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

    localparam int unsigned OFF_W = 62;
    localparam int unsigned LEN_W = 13;

    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_MARK_INV  = 3'd1;
    localparam logic [2:0] CMD_MARK_VAL  = 3'd2;
    localparam logic [2:0] CMD_CONSUME   = 3'd3;
    localparam logic [2:0] CMD_NEXT_VAL  = 3'd4;
    localparam logic [2:0] CMD_ANY_AFTER = 3'd5;

    localparam logic [LEN_W-1:0] ADV_MAX = 13'h1FFF;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [OFF_W-1:0] stream_offset;
        logic [LEN_W-1:0] range_length;
    } t_req_word;

    typedef struct packed {
        logic [LEN_W-1:0] advance_count;
        logic [OFF_W-1:0] found_offset;
        logic             found_flag;
    } t_rsp_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FILL_RD,
        S_FILL,
        S_SCAN_RD,
        S_SCAN,
        S_FIN
    } t_state;

    // word unit request and answer
    typedef struct packed {
        logic [31:0] data;
        logic [4:0]  bitpos;
        logic [5:0]  lim;     // bits still wanted, capped at 32
        logic        v;       // value written or scanned for
    } t_unit_in;

    typedef struct packed {
        logic [5:0]  k;       // bits of this word taken
        logic [31:0] wr_data;
        logic [5:0]  run;     // run of v from bitpos, at most k
    } t_unit_out;

endpackage

`default_nettype wire

// ===== hdl/srb_ram.sv =====
// ----------------------------------------------------------------------------
// srb_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/srb_word_unit.sv =====
// ----------------------------------------------------------------------------
// srb_word_unit
// shared per-word unit: range mask merge and run count over one bitmap word
// ----------------------------------------------------------------------------
`default_nettype none

module srb_word_unit (
    input  wire srb_pkg::t_unit_in  i_req,
    output      srb_pkg::t_unit_out o_ans
);
    import srb_pkg::*;

    logic [5:0]  avail;
    logic [5:0]  k;
    logic [31:0] lowm;
    logic [31:0] mask;
    logic [31:0] y;
    logic [5:0]  c;
    logic        hit;

    always_comb begin
        avail = 6'd32 - {1'b0, i_req.bitpos};
        k     = (i_req.lim < avail) ? i_req.lim : avail;
        lowm  = (k[5]) ? 32'hFFFF_FFFF : ((32'h1 << k[4:0]) - 32'h1);
        mask  = lowm << i_req.bitpos;
        y     = ((i_req.v ? i_req.data : ~i_req.data) >> i_req.bitpos) & lowm;
        // trailing ones of y
        c   = 6'd32;
        hit = 1'b0;
        for (int i = 0; i < 32; i++) begin
            if (!hit && !y[i]) begin
                c   = 6'(i);
                hit = 1'b1;
            end
        end
        o_ans.k       = k;
        o_ans.wr_data = i_req.v ? (i_req.data | mask) : (i_req.data & ~mask);
        o_ans.run     = c;
    end

endmodule

`default_nettype wire

// ===== hdl/stream_reassembly_bitmap.sv =====
// ----------------------------------------------------------------------------
// stream_reassembly_bitmap
// valid bitmap of a ring reassembly window with head and tail offsets
// ----------------------------------------------------------------------------
// sequence: a command that needs no fill or scan goes from prep to finish;
//   a fill or scan adds a ram read start state, then steps word by word over
//   the bitmap words it touches; insert with tail advance does a fill pass then a run scan
// throughput: one command at a time, busy until the result word shows
// the single word unit and one ram read port set the pace: one word a cycle
// reset: head, tail and all word valid bits clear together, no sweep
// the result word is shown for one cycle on o_valid, the receiver cannot stall
// WINDOW_BYTES must be a power of two
// ----------------------------------------------------------------------------
`default_nettype none

module stream_reassembly_bitmap #(
    parameter int unsigned WINDOW_BYTES = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire srb_pkg::t_req_word i_req,
    output logic                    o_valid,
    output srb_pkg::t_rsp_word      o_rsp
);
    import srb_pkg::*;

    localparam int unsigned PW     = $clog2(WINDOW_BYTES);  // ring position bits
    localparam int unsigned CW     = PW + 1;                 // count up to window
    localparam int unsigned AW     = PW - 5;                 // word address bits
    localparam int unsigned NWORDS = WINDOW_BYTES / 32;
    localparam int unsigned MW     = (CW > LEN_W) ? CW : LEN_W;
    localparam int unsigned AVW    = CW + 1;                 // insert advance

    // state
    t_state            r_state, n_state;
    logic [OFF_W-1:0]  r_head, n_head;
    logic [OFF_W-1:0]  r_tail, n_tail;
    logic [NWORDS-1:0] r_wvalid, n_wvalid;

    // command context
    logic [2:0]        r_cmd;
    logic [OFF_W-1:0]  r_off;
    logic [LEN_W-1:0]  r_len;
    logic [PW-1:0]     r_p, n_p;          // current ring position
    logic [CW-1:0]     r_n, n_n;          // bits left to fill or scan
    logic [CW-1:0]     r_d, n_d;          // scan limit for any valid after
    logic [CW-1:0]     r_run, n_run;      // scanned run
    logic [CW-1:0]     r_len_c, n_len_c;  // inserted length counted in advance
    logic              r_v, n_v;
    logic              r_at_tail, n_at_tail;
    logic              r_pre_flag, n_pre_flag;
    logic              r_rdv;

    logic              r_valid, n_valid;
    t_rsp_word         r_rsp, n_rsp;

    // ram and unit
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [31:0]       mem_rdata;
    t_unit_in          u_in;
    t_unit_out         u_out;

    // insert preparation
    logic [OFF_W:0]    ins_sum;
    logic              ins_new;
    logic              off_lt_tail;
    logic [OFF_W-1:0]  tail_minus_off;
    logic [LEN_W-1:0]  len_trim;
    logic [CW-1:0]     len_clamp;
    logic [CW-1:0]     mark_clamp;
    logic [PW-1:0]     head_pos;
    logic [PW-1:0]     off_pos;
    logic [PW-1:0]     tail_pos;
    logic [PW-1:0]     step_p;
    logic [CW-1:0]     step_n;
    logic              scan_stop;

    // finish arithmetic
    logic [AVW-1:0]    ins_adv;
    logic [OFF_W:0]    nv_sum;

    srb_ram #(
        .WIDTH (32),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_p[PW-1:5]),
        .i_wr_data (u_out.wr_data),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    srb_word_unit u_unit (
        .i_req (u_in),
        .o_ans (u_out)
    );

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // word unit feed: never-written words read as zero
    always_comb begin
        u_in.data   = r_rdv ? mem_rdata : 32'h0;
        u_in.bitpos = r_p[4:0];
        u_in.lim    = (r_n > CW'(32)) ? 6'd32 : r_n[5:0];
        u_in.v      = r_v;
    end

    always_comb begin
        head_pos       = r_head[PW-1:0];
        off_pos        = r_off[PW-1:0];
        tail_pos       = r_tail[PW-1:0];
        ins_sum        = {1'b0, r_off} + (OFF_W+1)'(r_len);
        ins_new        = ins_sum > {1'b0, r_tail};
        off_lt_tail    = r_off < r_tail;
        tail_minus_off = r_tail - r_off;
        len_trim       = off_lt_tail ? (r_len - tail_minus_off[LEN_W-1:0]) : r_len;
        len_clamp      = (MW'(len_trim) > MW'(WINDOW_BYTES)) ? CW'(WINDOW_BYTES)
                                                             : CW'(len_trim);
        mark_clamp     = (MW'(r_len) > MW'(WINDOW_BYTES)) ? CW'(WINDOW_BYTES)
                                                          : CW'(r_len);
        step_p         = r_p + PW'(u_out.k);
        step_n         = r_n - CW'(u_out.k);
        scan_stop      = (u_out.run < u_out.k) || (r_n == CW'(u_out.k));
        ins_adv        = AVW'(r_len_c) + AVW'(r_run);
        nv_sum         = {1'b0, r_off} + (OFF_W+1)'(r_run);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_wvalid   = r_wvalid;
        n_p        = r_p;
        n_n        = r_n;
        n_d        = r_d;
        n_run      = r_run;
        n_len_c    = r_len_c;
        n_v        = r_v;
        n_at_tail  = r_at_tail;
        n_pre_flag = r_pre_flag;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_p[PW-1:5];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PREP;
                end
            end

            S_PREP: begin
                n_run      = '0;
                n_d        = '0;
                n_len_c    = '0;
                n_at_tail  = 1'b0;
                n_pre_flag = 1'b0;
                n_state    = S_FIN;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (ins_new) begin
                            n_at_tail = off_lt_tail || (r_off == r_tail);
                            n_len_c   = (off_lt_tail || (r_off == r_tail)) ? len_clamp
                                                                         : '0;
                            n_p       = off_lt_tail ? tail_pos : off_pos;
                            n_n       = len_clamp;
                            n_v       = 1'b1;
                            n_state   = S_FILL_RD;
                        end
                    end
                    CMD_MARK_INV, CMD_MARK_VAL: begin
                        n_p     = off_pos;
                        n_n     = mark_clamp;
                        n_v     = (r_cmd == CMD_MARK_VAL);
                        n_state = S_FILL_RD;
                    end
                    CMD_CONSUME: begin
                        n_p     = head_pos;
                        n_n     = CW'(PW'(off_pos - head_pos));
                        n_v     = 1'b0;
                        n_state = S_SCAN_RD;
                    end
                    CMD_NEXT_VAL: begin
                        n_p     = off_pos;
                        n_n     = CW'(PW'(tail_pos - off_pos));
                        n_v     = 1'b0;
                        n_state = S_SCAN_RD;
                    end
                    CMD_ANY_AFTER: begin
                        if (off_lt_tail) begin
                            n_pre_flag = 1'b1;
                        end else begin
                            n_p     = off_pos;
                            n_n     = CW'(PW'(head_pos - off_pos));
                            n_d     = CW'(PW'(head_pos - off_pos));
                            n_v     = 1'b0;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            S_FILL_RD: begin
                if (r_n == '0) begin
                    // empty range: go straight to the tail run scan if any
                    if (r_at_tail) begin
                        n_n     = CW'(PW'(head_pos - r_p));
                        n_v     = 1'b1;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_FILL;
                end
            end

            S_FILL: begin
                mem_we             = 1'b1;
                n_wvalid[r_p[PW-1:5]] = 1'b1;
                n_p                = step_p;
                n_n                = step_n;
                if (step_n == '0) begin
                    // fill ends at the range end, where the tail run starts
                    if (r_at_tail) begin
                        n_n     = CW'(PW'(head_pos - step_p));
                        n_v     = 1'b1;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = step_p[PW-1:5];
                end
            end

            S_SCAN_RD: begin
                if (r_n == '0) begin
                    n_state = S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                if (scan_stop) begin
                    n_run   = r_run + CW'(u_out.run);
                    n_state = S_FIN;
                end else begin
                    n_run     = r_run + CW'(u_out.k);
                    n_p       = step_p;
                    n_n       = step_n;
                    mem_re    = 1'b1;
                    mem_raddr = step_p[PW-1:5];
                end
            end

            S_FIN: begin
                n_valid = 1'b1;
                n_rsp   = '0;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        n_tail = r_tail + OFF_W'(ins_adv);
                        n_rsp.advance_count = (ins_adv > AVW'(ADV_MAX)) ? ADV_MAX
                                                                       : LEN_W'(ins_adv);
                    end
                    CMD_CONSUME: begin
                        n_head = r_head + OFF_W'(r_run);
                        n_rsp.advance_count = (MW'(r_run) > MW'(ADV_MAX)) ? ADV_MAX
                                                                         : LEN_W'(r_run);
                    end
                    CMD_NEXT_VAL: begin
                        n_rsp.found_offset = nv_sum[OFF_W-1:0];
                        n_rsp.found_flag   = nv_sum < {1'b0, r_tail};
                    end
                    CMD_ANY_AFTER: begin
                        n_rsp.found_flag = r_pre_flag || (r_run < r_d);
                    end
                    default: begin
                        n_rsp = '0;
                    end
                endcase
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_wvalid <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_wvalid <= n_wvalid;
            r_valid  <= n_valid;
        end
    end

    // command context and result word
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_cmd <= i_req.cmd;
            r_off <= i_req.stream_offset;
            r_len <= i_req.range_length;
        end
        if (mem_re) begin
            r_rdv <= r_wvalid[mem_raddr];
        end
        r_p        <= n_p;
        r_n        <= n_n;
        r_d        <= n_d;
        r_run      <= n_run;
        r_len_c    <= n_len_c;
        r_v        <= n_v;
        r_at_tail  <= n_at_tail;
        r_pre_flag <= n_pre_flag;
        r_rsp      <= n_rsp;
    end

endmodule

`default_nettype wire

// ===== hdl/srb_checker.sv =====
// ----------------------------------------------------------------------------
// srb_checker
// port level checks of the stream reassembly bitmap
// ----------------------------------------------------------------------------
`default_nettype none

module srb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire srb_pkg::t_rsp_word o_rsp
);
    import srb_pkg::*;

    // a result word only shows when the block has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("command accepted without going busy");

    // a result word comes only at the end of busy
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a command");

    // one result per command
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result word repeated");

    // found flag and offset only come from queries, advance never with flag
    a_adv_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.advance_count != '0)) |-> !o_rsp.found_flag)
        else $error("advance and found flag together");

endmodule

bind stream_reassembly_bitmap srb_checker u_srb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

`default_nettype wire
